// ----- src/per_client_fixed_window_policer_defines.svh -----
//------------------------------------------------------------------------------
// Per-client fixed window policer: assertion macros
// Shared concurrent assertion forms used by the policer RTL.
//------------------------------------------------------------------------------
`ifndef PER_CLIENT_FIXED_WINDOW_POLICER_DEFINES_SVH
`define PER_CLIENT_FIXED_WINDOW_POLICER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCFWP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("policer assertion failed");

// Next-cycle implication, checked outside reset.
`define PCFWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("policer assertion failed");

`endif

// ----- src/pcfwp_pkg.sv -----
//------------------------------------------------------------------------------
// pcfwp_pkg
// Types and constants shared by the per-client fixed window policer.
//------------------------------------------------------------------------------
package pcfwp_pkg;

  localparam int SLOT_W  = 7;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 15;
  localparam int CFG_INDEX_W = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 15'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd128;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [ID_W-1:0]    NO_OWNER    = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_PER_WINDOW = 1'b0,
    REG_KICK_ENABLE    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_MALFORMED = 2'd1,
    REASON_RATE      = 2'd2
  } reason_t;

  // One slot's record as it sits in the state memory.
  typedef struct packed {
    logic [ID_W-1:0]    owner;
    logic [TIME_W-1:0]  start;
    logic [COUNT_W-1:0] count;
    logic               caught;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    owner:  NO_OWNER,
    start:  '0,
    count:  '0,
    caught: 1'b0
  };

  typedef struct packed {
    logic              pass;
    reason_t           reason;
    logic              newly_caught;
    logic              kick_request;
    logic [SLOT_W-1:0] kick_slot;
    logic [ID_W-1:0]   kick_client_id;
  } result_t;

endpackage

// ----- src/pcfwp_ram.sv -----
//------------------------------------------------------------------------------
// pcfwp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
//------------------------------------------------------------------------------
module pcfwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/pcfwp_update.sv -----
//------------------------------------------------------------------------------
// pcfwp_update
// Read-modify-write logic: takes one slot record and a request, returns the
// record to write back and the result of the request.
//------------------------------------------------------------------------------
module pcfwp_update
  import pcfwp_pkg::*;
#(
  parameter int WINDOW_MS = 1000
) (
  input  entry_t              entry_in,
  input  logic                in_range,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [ID_W-1:0]     client_id,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic                malformed,
  input  logic [LIMIT_W-1:0]  max_per_window,
  input  logic                kick_enable,
  output entry_t              entry_out,
  output result_t             result
);

  localparam logic [TIME_W-1:0] WINDOW = TIME_W'(WINDOW_MS);

  entry_t             owned;
  logic [TIME_W-1:0]  elapsed;
  logic [COUNT_W-1:0] base_count;
  logic [COUNT_W-1:0] count_next;
  reason_t            reason;
  logic               newly;
  logic               kick;

  always_comb begin
    // A different client on the slot starts from a clean record.
    owned = entry_in;
    if (entry_in.owner != client_id) begin
      owned       = ENTRY_RESET;
      owned.owner = client_id;
    end

    elapsed    = now_ms - owned.start;
    entry_out  = owned;
    base_count = owned.count;
    count_next = owned.count;
    reason     = REASON_NONE;

    if (malformed) begin
      reason = REASON_MALFORMED;
    end else begin
      if (elapsed >= WINDOW) begin
        entry_out.start = now_ms;
        base_count      = '0;
      end
      count_next = (base_count != COUNT_MAX) ? base_count + 1'b1 : base_count;
      entry_out.count = count_next;
      if (count_next > {1'b0, max_per_window}) begin
        reason = REASON_RATE;
      end
    end

    newly = (reason != REASON_NONE) && !owned.caught;
    kick  = newly && kick_enable;
    if (newly) begin
      entry_out.caught = 1'b1;
    end

    result.pass           = (reason == REASON_NONE) && !owned.caught;
    result.reason         = reason;
    result.newly_caught   = newly;
    result.kick_request   = kick;
    result.kick_slot      = kick ? slot : '0;
    result.kick_client_id = kick ? client_id : '0;

    // Slots beyond the table pass untouched.
    if (!in_range) begin
      result        = '0;
      result.pass   = 1'b1;
      result.reason = REASON_NONE;
    end
  end

endmodule

// ----- src/per_client_fixed_window_policer.sv -----
//------------------------------------------------------------------------------
// Per-client fixed window policer
// Polices voice messages per client slot over a fixed one-second window.
//------------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with slot, client_id, now_ms and
//   malformed. Each request yields exactly one result on out_valid/out_ready:
//   pass, reason, newly_caught, kick_request, kick_slot and kick_client_id.
//   The accept edge reads the slot's record from the state memory; in S_CALC,
//   once the output register is free, the updated record is written back and
//   the result register loaded, which raises out_valid. One request is in
//   flight at a time, so the block takes no new request until the current one
//   has written its record back.
//   A waiting result does not block the next accept; a further result waits
//   in the update stage until the output register is free, which stalls
//   in_ready while the receiver holds out_ready low.
//   Reset clears the per-slot valid bits, so every slot reads as having no
//   owner, no window and no catch, sets max_per_window to 128 and
//   kick_enable to 1. There is no clearing pass; requests are taken at once.
//   The user makes configuration writes through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
//------------------------------------------------------------------------------
`include "per_client_fixed_window_policer_defines.svh"

module per_client_fixed_window_policer
  import pcfwp_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int WINDOW_MS  = 1000
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SLOT_W-1:0]      slot,
  input  logic [ID_W-1:0]        client_id,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic                   malformed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   pass,
  output logic [1:0]             reason,
  output logic                   newly_caught,
  output logic                   kick_request,
  output logic [SLOT_W-1:0]      kick_slot,
  output logic [ID_W-1:0]        kick_client_id
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int EW = $bits(entry_t);
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t             state;
  logic [LIMIT_W-1:0] max_per_window;
  logic               kick_enable;
  logic [SLOT_COUNT-1:0] valid_bits;

  logic [SLOT_W-1:0]  req_slot;
  logic [ID_W-1:0]    req_id;
  logic [TIME_W-1:0]  req_now;
  logic               req_bad;
  logic               req_in_range;
  logic               req_hit;

  logic               accept;
  logic               in_range;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      req_addr;
  logic               out_free;
  logic               finish;
  logic               ram_we;
  logic [EW-1:0]      ram_rdata;
  entry_t             entry_cur;
  entry_t             entry_new;
  result_t            result;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, slot} < SLOT_LIMIT);
  assign in_addr  = slot[AW-1:0];
  assign req_addr = req_slot[AW-1:0];
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_CALC) && out_free;
  assign ram_we   = finish && req_in_range;

  // A slot never written since reset reads as its reset record.
  assign entry_cur = req_hit ? entry_t'(ram_rdata) : ENTRY_RESET;

  pcfwp_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_addr),
    .wdata (EW'(entry_new)),
    .re    (accept && in_range),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  pcfwp_update #(
    .WINDOW_MS (WINDOW_MS)
  ) u_update (
    .entry_in       (entry_cur),
    .in_range       (req_in_range),
    .slot           (req_slot),
    .client_id      (req_id),
    .now_ms         (req_now),
    .malformed      (req_bad),
    .max_per_window (max_per_window),
    .kick_enable    (kick_enable),
    .entry_out      (entry_new),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      max_per_window <= LIMIT_RESET;
      kick_enable    <= 1'b1;
      valid_bits     <= '0;
      out_valid      <= 1'b0;
      req_in_range   <= 1'b0;
      req_hit        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_PER_WINDOW: begin
            max_per_window <= (cfg_data < LIMIT_MIN) ? LIMIT_MIN : cfg_data;
          end
          REG_KICK_ENABLE: begin
            kick_enable <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      // A new result may replace the one taken at this same edge.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_in_range <= in_range;
            req_hit      <= in_range && valid_bits[in_addr];
            state        <= S_CALC;
          end
        end
        S_CALC: begin
          if (out_free) begin
            if (req_in_range) begin
              valid_bits[req_addr] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_slot <= slot;
      req_id   <= client_id;
      req_now  <= now_ms;
      req_bad  <= malformed;
    end
    if (finish) begin
      pass           <= result.pass;
      reason         <= result.reason;
      newly_caught   <= result.newly_caught;
      kick_request   <= result.kick_request;
      kick_slot      <= result.kick_slot;
      kick_client_id <= result.kick_client_id;
    end
  end

  `PCFWP_ASSERT_NEXT(a_accept_to_calc, clk, rst, accept, state == S_CALC)
  `PCFWP_ASSERT_SAME(a_write_needs_room, clk, rst, ram_we, out_free && state == S_CALC)
  `PCFWP_ASSERT_SAME(a_kick_is_new, clk, rst, out_valid && kick_request, newly_caught && !pass)
  `PCFWP_ASSERT_SAME(a_limit_floor, clk, rst, 1'b1, max_per_window >= LIMIT_MIN)
  `PCFWP_ASSERT_NEXT(a_finish_gives_result, clk, rst, finish, out_valid)

endmodule
